// ===== rtl/core/ils_pkg.sv =====
// Package for the indexed list store: item types, action and status codes,
// and the sequencer states. No dependencies.
`default_nettype none

package ils_pkg;

  // Action codes of an input item.
  localparam logic [2:0] ACT_READ     = 3'd0;
  localparam logic [2:0] ACT_INS_POS  = 3'd1;
  localparam logic [2:0] ACT_DELETE   = 3'd2;
  localparam logic [2:0] ACT_INS_HEAD = 3'd3;
  localparam logic [2:0] ACT_INS_TAIL = 3'd4;

  // Status codes of a result item.
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         action;
    logic [8:0]         position;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [8:0]         element_count;
  } out_item_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_ALLOC,
    S_POP,
    S_PLACE,
    S_WALK,
    S_LINK,
    S_INS2,
    S_DHEAD,
    S_DVIC,
    S_DNEXT,
    S_DFREE,
    S_RDOUT
  } ils_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/ils_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module ils_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; a read returns the old data on a collision.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/indexed_list_store_top.sv =====
// Indexed list store: a bounded ordered list kept as linked slots in RAM.
// Depends on ils_pkg and ils_ram.
`default_nettype none

// Usage:
// An item is taken at a rising edge where start is high and busy is low. It
// reads the element at a position, inserts a value at the head, the tail or
// before a position, or deletes the element at a position. Every item gives
// exactly one result on out_item, marked by out_strobe for one cycle; the
// receiver must take it then. The result carries the element count after the
// item. Values live in a value RAM, list order and the free chain in a link
// RAM; both have a registered read.
// An out-of-range position, a full list or an unknown action is reported
// straight from idle. A read walks to position p and reads its value. An
// insert takes a fresh slot or pops one off the free chain, then links it at
// the head or walks to the predecessor and links it there (p = count for a
// tail insert). A delete unhooks the head or walks to the predecessor and
// pushes the victim on the free chain. The walk along the links, one link
// RAM read per cycle, sets how long an item takes. busy stays high until the
// result is registered, so one item is in work at a time.
// Reset empties the list at once; no RAM clearing pass is needed, since slots
// are handed out from a fresh-slot counter first and from the free chain
// after that.
module indexed_list_store_top
  import ils_pkg::*;
#(
  parameter int CAPACITY   = 256,
  parameter int VALUE_BITS = 32
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  in_item,
  output logic           out_strobe,
  output out_item_t      out_item
);

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int PW     = (CNT_W > 9) ? CNT_W : 9;

  ils_state_t          state_r, state_nxt;
  logic [2:0]          op_r, op_nxt;
  logic [PW-1:0]       k_r, k_nxt;
  logic                walk_first_r, walk_first_nxt;
  logic signed [31:0]  val_r, val_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [SLOT_W-1:0]   prev_r, prev_nxt;
  logic [SLOT_W-1:0]   victim_r, victim_nxt;
  logic [SLOT_W-1:0]   first_r, first_nxt;
  logic [SLOT_W-1:0]   free_head_r, free_head_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    fresh_r, fresh_nxt;
  out_item_t           out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic                links_we;
  logic [SLOT_W-1:0]   links_waddr, links_wdata, links_raddr, links_rdata;
  logic                vals_we;
  logic [SLOT_W-1:0]   vals_waddr, vals_raddr;
  logic [VALUE_BITS-1:0] vals_wdata, vals_rdata;

  logic [SLOT_W-1:0]   cur_slot;
  logic [PW-1:0]       pos_ext, count_ext, eff_pos, count_nxt_ext;
  logic [VALUE_BITS+31:0] wr_ext;
  logic [VALUE_BITS+31:0] rd_ext;
  logic                accept;

  // Link RAM: next slot in list order, or next slot on the free chain.
  ils_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_links (
    .clk   (clk),
    .we    (links_we),
    .waddr (links_waddr),
    .wdata (links_wdata),
    .raddr (links_raddr),
    .rdata (links_rdata)
  );

  // Value RAM: one element per slot.
  ils_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_vals (
    .clk   (clk),
    .we    (vals_we),
    .waddr (vals_waddr),
    .wdata (vals_wdata),
    .raddr (vals_raddr),
    .rdata (vals_rdata)
  );

  assign busy       = (state_r != S_IDLE);
  assign accept     = start && !busy;
  assign out_strobe = out_valid_r;
  assign out_item   = out_r;

  // Widening helpers for positions, counts and values.
  assign pos_ext   = PW'(in_item.position);
  assign count_ext = PW'(count_r);
  assign wr_ext    = {{VALUE_BITS{1'b0}}, val_r};
  assign rd_ext    = {32'b0, vals_rdata};
  assign vals_wdata = wr_ext[VALUE_BITS-1:0];

  // Slot reached by the walk: the first slot, then the link just read.
  assign cur_slot = walk_first_r ? first_r : links_rdata;

  // Position that an insert actually uses.
  always_comb begin
    case (in_item.action)
      ACT_INS_HEAD: eff_pos = '0;
      ACT_INS_TAIL: eff_pos = count_ext;
      default:      eff_pos = pos_ext;
    endcase
  end

  // Sequencer: next state, RAM accesses and the result.
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    k_nxt          = k_r;
    walk_first_nxt = walk_first_r;
    val_nxt        = val_r;
    slot_nxt       = slot_r;
    prev_nxt       = prev_r;
    victim_nxt     = victim_r;
    first_nxt      = first_r;
    free_head_nxt  = free_head_r;
    count_nxt      = count_r;
    fresh_nxt      = fresh_r;
    out_nxt        = out_r;
    out_valid_nxt  = 1'b0;
    links_we       = 1'b0;
    links_waddr    = slot_r;
    links_wdata    = first_r;
    links_raddr    = cur_slot;
    vals_we        = 1'b0;
    vals_waddr     = slot_r;
    vals_raddr     = cur_slot;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_nxt.read_value = '0;
          out_nxt.status     = ST_DONE;
          walk_first_nxt     = 1'b1;
          val_nxt            = in_item.value;
          case (in_item.action)
            ACT_READ: begin
              if (pos_ext >= count_ext) begin
                out_nxt.read_value = '1;
                out_nxt.status     = ST_RANGE;
                out_valid_nxt      = 1'b1;
              end else begin
                op_nxt    = ACT_READ;
                k_nxt     = pos_ext;
                state_nxt = S_WALK;
              end
            end
            ACT_INS_POS, ACT_INS_HEAD, ACT_INS_TAIL: begin
              if (eff_pos > count_ext) begin
                out_nxt.status = ST_RANGE;
                out_valid_nxt  = 1'b1;
              end else if (count_r == CNT_W'(CAPACITY)) begin
                out_nxt.status = ST_FULL;
                out_valid_nxt  = 1'b1;
              end else begin
                op_nxt    = ACT_INS_POS;
                k_nxt     = eff_pos;
                state_nxt = S_ALLOC;
              end
            end
            ACT_DELETE: begin
              if (pos_ext >= count_ext) begin
                out_nxt.status = ST_RANGE;
                out_valid_nxt  = 1'b1;
              end else if (pos_ext == '0) begin
                op_nxt      = ACT_DELETE;
                victim_nxt  = first_r;
                links_raddr = first_r;
                state_nxt   = S_DHEAD;
              end else begin
                op_nxt    = ACT_DELETE;
                k_nxt     = pos_ext - PW'(1);
                state_nxt = S_WALK;
              end
            end
            default: begin
              out_nxt.status = ST_RANGE;
              out_valid_nxt  = 1'b1;
            end
          endcase
        end
      end

      // Take a never-used slot while there is one, else pop the free chain.
      S_ALLOC: begin
        if (fresh_r != CNT_W'(CAPACITY)) begin
          slot_nxt   = fresh_r[SLOT_W-1:0];
          fresh_nxt  = fresh_r + CNT_W'(1);
          vals_we    = 1'b1;
          vals_waddr = fresh_r[SLOT_W-1:0];
          state_nxt  = S_PLACE;
        end else begin
          links_raddr = free_head_r;
          state_nxt   = S_POP;
        end
      end

      S_POP: begin
        slot_nxt      = free_head_r;
        free_head_nxt = links_rdata;
        vals_we       = 1'b1;
        vals_waddr    = free_head_r;
        state_nxt     = S_PLACE;
      end

      // Head insert finishes here; otherwise walk to the predecessor.
      S_PLACE: begin
        if (k_r == '0) begin
          links_we      = 1'b1;
          links_waddr   = slot_r;
          links_wdata   = first_r;
          first_nxt     = slot_r;
          count_nxt     = count_r + CNT_W'(1);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          k_nxt          = k_r - PW'(1);
          walk_first_nxt = 1'b1;
          state_nxt      = S_WALK;
        end
      end

      // One link per cycle until the target slot is reached.
      S_WALK: begin
        if (k_r == '0) begin
          prev_nxt = cur_slot;
          case (op_r)
            ACT_READ:   state_nxt = S_RDOUT;
            ACT_DELETE: state_nxt = S_DVIC;
            default:    state_nxt = S_LINK;
          endcase
        end else begin
          k_nxt          = k_r - PW'(1);
          walk_first_nxt = 1'b0;
        end
      end

      // New slot takes over the predecessor's link.
      S_LINK: begin
        links_we    = 1'b1;
        links_waddr = slot_r;
        links_wdata = links_rdata;
        state_nxt   = S_INS2;
      end

      S_INS2: begin
        links_we      = 1'b1;
        links_waddr   = prev_r;
        links_wdata   = slot_r;
        count_nxt     = count_r + CNT_W'(1);
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      // Head delete: unhook the first slot and push it on the free chain.
      S_DHEAD: begin
        first_nxt     = links_rdata;
        links_we      = 1'b1;
        links_waddr   = victim_r;
        links_wdata   = free_head_r;
        free_head_nxt = victim_r;
        count_nxt     = count_r - CNT_W'(1);
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      S_DVIC: begin
        victim_nxt  = links_rdata;
        links_raddr = links_rdata;
        state_nxt   = S_DNEXT;
      end

      S_DNEXT: begin
        links_we    = 1'b1;
        links_waddr = prev_r;
        links_wdata = links_rdata;
        state_nxt   = S_DFREE;
      end

      S_DFREE: begin
        links_we      = 1'b1;
        links_waddr   = victim_r;
        links_wdata   = free_head_r;
        free_head_nxt = victim_r;
        count_nxt     = count_r - CNT_W'(1);
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      S_RDOUT: begin
        out_nxt.read_value = rd_ext[31:0];
        out_valid_nxt      = 1'b1;
        state_nxt          = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    count_nxt_ext          = PW'(count_nxt);
    out_nxt.element_count  = count_nxt_ext[8:0];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      fresh_r     <= '0;
      first_r     <= '0;
      free_head_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      fresh_r     <= fresh_nxt;
      first_r     <= first_nxt;
      free_head_r <= free_head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    k_r          <= k_nxt;
    walk_first_r <= walk_first_nxt;
    val_r        <= val_nxt;
    slot_r       <= slot_nxt;
    prev_r       <= prev_nxt;
    victim_r     <= victim_nxt;
    out_r        <= out_nxt;
  end

  // Every accepted item either reports at once or keeps the block busy.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (out_strobe || busy))
    else $error("accepted item neither reported nor in work");

  // The count never exceeds the capacity or the slots ever handed out.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= CNT_W'(CAPACITY)) && (count_r <= fresh_r))
    else $error("element count out of bounds");

  // A full status is reported only when the list is full.
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_item.status == ST_FULL)) |-> (count_r == CNT_W'(CAPACITY)))
    else $error("full status with room left");

  // The count moves only together with a result.
  a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |-> out_strobe)
    else $error("count changed without a result");

endmodule

`default_nettype wire
